// ----- hw/rtl/cuckoo_hash_table_assert.svh -----
// Assertion macros for the cuckoo hash table RTL.
`ifndef CUCKOO_HASH_TABLE_ASSERT_SVH
`define CUCKOO_HASH_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CHT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/cht_pkg.sv -----
`default_nettype none

package cht_pkg;

  localparam int KEY_W        = 64;
  localparam int VAL_W        = 16;
  localparam int SLOT_W       = 13;
  localparam int SECOND_SHIFT = 16;
  localparam int ENTRY_W      = KEY_W + VAL_W;
  localparam int IN_DATA_W    = 80;
  localparam int OUT_DATA_W   = 32;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Read address sources.
  localparam logic [1:0] ADDR_IN_FIRST = 2'd0;
  localparam logic [1:0] ADDR_SECOND   = 2'd1;
  localparam logic [1:0] ADDR_IDX      = 2'd2;

  // Result kinds.
  localparam logic [1:0] RES_MISS = 2'd0;
  localparam logic [1:0] RES_HIT  = 2'd1;
  localparam logic [1:0] RES_OK   = 2'd2;
  localparam logic [1:0] RES_FAIL = 2'd3;

  typedef struct packed {
    logic       load_in;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       wr_clear;
    logic       wr_ins;
    logic       res_load;
    logic [1:0] res_kind;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic hit;
    logic old_empty;
    logic kicks_done;
    logic in_lookup;
    logic in_val_zero;
  } sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/cht_ram.sv -----
`default_nettype none

module cht_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/cht_datapath.sv -----
`default_nettype none

module cht_datapath
  import cht_pkg::*;
#(
  parameter int INDEX_BITS = 13,
  parameter int MAX_KICKS  = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [IN_DATA_W-1:0]   s_tdata,
  input  wire logic [0:0]             s_tuser,
  input  wire cmd_t                   cmd,
  output sts_t                        sts,
  output logic      [OUT_DATA_W-1:0]  m_tdata
);

  localparam int DEPTH  = 1 << INDEX_BITS;
  localparam int KICK_W = $clog2(MAX_KICKS + 1);

  logic [KEY_W-1:0]      in_key;
  logic [VAL_W-1:0]      in_val;
  logic [KEY_W-1:0]      cur_key;
  logic [VAL_W-1:0]      cur_val;
  logic [INDEX_BITS-1:0] idx;
  logic [INDEX_BITS-1:0] home;
  logic [INDEX_BITS-1:0] clr_cnt;
  logic [INDEX_BITS-1:0] rd_addr_q;
  logic [KICK_W-1:0]     kicks;

  logic [INDEX_BITS-1:0] rd_addr;
  logic [INDEX_BITS-1:0] wr_addr;
  logic [ENTRY_W-1:0]    wr_data;
  logic [ENTRY_W-1:0]    rd_data;
  logic [KEY_W-1:0]      rd_key;
  logic [VAL_W-1:0]      rd_val;
  logic [INDEX_BITS-1:0] old_first;
  logic [INDEX_BITS-1:0] old_second;

  logic                  found;
  logic [VAL_W-1:0]      value_out;
  logic [SLOT_W-1:0]     slot;
  logic                  insert_failed;

  assign in_key = s_tdata[KEY_W-1:0];
  assign in_val = s_tdata[KEY_W +: VAL_W];
  assign rd_key = rd_data[VAL_W +: KEY_W];
  assign rd_val = rd_data[VAL_W-1:0];

  assign old_first  = rd_key[INDEX_BITS-1:0];
  assign old_second = rd_key[SECOND_SHIFT +: INDEX_BITS];

  always_comb begin
    case (cmd.rd_sel)
      ADDR_IN_FIRST: rd_addr = in_key[INDEX_BITS-1:0];
      ADDR_SECOND:   rd_addr = cur_key[SECOND_SHIFT +: INDEX_BITS];
      default:       rd_addr = idx;
    endcase
  end

  assign wr_addr = cmd.wr_clear ? clr_cnt : idx;
  assign wr_data = cmd.wr_clear ? '0 : {cur_key, cur_val};

  cht_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (cmd.wr_clear | cmd.wr_ins),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.wr_clear) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_addr_q <= rd_addr;
    end
    if (cmd.load_in) begin
      cur_key <= in_key;
      cur_val <= in_val;
      idx     <= in_key[INDEX_BITS-1:0];
      home    <= in_key[INDEX_BITS-1:0];
      kicks   <= '0;
    end else if (cmd.wr_ins) begin
      // The displaced entry moves on to whichever of its slots it did not occupy.
      cur_key <= rd_key;
      cur_val <= rd_val;
      idx     <= (idx == old_first) ? old_second : old_first;
      if (!sts.kicks_done) begin
        kicks <= kicks + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      case (cmd.res_kind)
        RES_HIT: begin
          found         <= 1'b1;
          value_out     <= rd_val;
          slot          <= SLOT_W'(rd_addr_q);
          insert_failed <= 1'b0;
        end
        RES_OK: begin
          found         <= 1'b1;
          value_out     <= '0;
          slot          <= SLOT_W'(home);
          insert_failed <= 1'b0;
        end
        RES_FAIL: begin
          found         <= 1'b0;
          value_out     <= '0;
          slot          <= SLOT_W'(home);
          insert_failed <= 1'b1;
        end
        default: begin
          found         <= 1'b0;
          value_out     <= '0;
          slot          <= SLOT_W'(home);
          insert_failed <= 1'b0;
        end
      endcase
    end
  end

  assign m_tdata = {1'b0, insert_failed, slot, value_out, found};

  assign sts.clr_last    = (clr_cnt == INDEX_BITS'(DEPTH - 1));
  assign sts.hit         = (rd_val != '0) && (rd_key == cur_key);
  assign sts.old_empty   = (rd_val == '0);
  assign sts.kicks_done  = (kicks >= KICK_W'(MAX_KICKS));
  assign sts.in_lookup   = (s_tuser[0] == OP_LOOKUP);
  assign sts.in_val_zero = (in_val == '0);

endmodule

`default_nettype wire

// ----- hw/rtl/cht_ctrl.sv -----
`default_nettype none

module cht_ctrl
  import cht_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic      s_tready,
  output logic      m_tvalid,
  input  wire logic m_tready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_LK_A   = 3'd2;
  localparam logic [2:0] S_LK_B   = 3'd3;
  localparam logic [2:0] S_INS_RD = 3'd4;
  localparam logic [2:0] S_INS_WR = 3'd5;
  localparam logic [2:0] S_RESULT = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [1:0] res_kind;
  logic [1:0] res_kind_next;
  logic       finish;
  logic [1:0] fin_kind;
  logic       out_free;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    cmd           = '0;
    state_next    = state;
    res_kind_next = res_kind;
    finish        = 1'b0;
    fin_kind      = RES_MISS;

    case (state)
      S_CLEAR: begin
        cmd.wr_clear = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          if (sts.in_lookup) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = ADDR_IN_FIRST;
            state_next = S_LK_A;
          end else if (sts.in_val_zero) begin
            // A zero payload would read as empty, so the request leaves the table alone.
            res_kind_next = RES_MISS;
            state_next    = S_RESULT;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = ADDR_IN_FIRST;
            state_next = S_INS_WR;
          end
        end
      end
      S_LK_A: begin
        if (sts.hit) begin
          finish   = 1'b1;
          fin_kind = RES_HIT;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ADDR_SECOND;
          state_next = S_LK_B;
        end
      end
      S_LK_B: begin
        finish   = 1'b1;
        fin_kind = sts.hit ? RES_HIT : RES_MISS;
      end
      S_INS_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = ADDR_IDX;
        state_next = S_INS_WR;
      end
      S_INS_WR: begin
        cmd.wr_ins = 1'b1;
        if (sts.old_empty) begin
          finish   = 1'b1;
          fin_kind = RES_OK;
        end else if (sts.kicks_done) begin
          finish   = 1'b1;
          fin_kind = RES_FAIL;
        end else begin
          state_next = S_INS_RD;
        end
      end
      S_RESULT: begin
        finish   = 1'b1;
        fin_kind = res_kind;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (finish) begin
      if (out_free) begin
        cmd.res_load = 1'b1;
        cmd.res_kind = fin_kind;
        state_next   = S_IDLE;
      end else begin
        res_kind_next = fin_kind;
        state_next    = S_RESULT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.res_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_kind <= res_kind_next;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/cuckoo_hash_table.sv -----
// Two-choice cuckoo hash table of 64-bit keys carrying 16-bit payloads.
// Input stream: s_tuser selects the operation (insert or lookup), s_tdata carries
// the key and the payload. Output stream: one result transfer per input transfer,
// in order, carrying found, value_out, slot and insert_failed.
// All table traffic goes through one table memory with a registered read, used for
// either a read or a write in any cycle, never both, so each probe is a read and
// each placement a write.
// Lookup: a hit in the first slot finishes without a second read, otherwise the
// second slot is read too; the next item is taken once the controller is idle again.
// Insert: the first placement, then a read and a write for each kick of the
// eviction chain (up to MAX_KICKS kicks); a zero payload insert leaves the table alone.
// After reset the table is swept to zero, one entry a cycle, over all 2**INDEX_BITS
// entries; s_tready stays low during the sweep.
// The result sits in an output register. While it waits, the next item is accepted
// and worked on; its result is held back until the register is taken, and only
// then does s_tready return high.
`default_nettype none
`include "cuckoo_hash_table_assert.svh"

module cuckoo_hash_table
  import cht_pkg::*;
#(
  parameter int INDEX_BITS = 13,
  parameter int MAX_KICKS  = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,   // key[63:0], value[79:64]
  input  wire logic [0:0]            s_tuser,   // op[0]
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic      [OUT_DATA_W-1:0] m_tdata    // found[0], value_out[16:1], slot[29:17],
                                                // insert_failed[30], zero[31]
);

  cmd_t cmd;
  sts_t sts;

  cht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cht_datapath #(
    .INDEX_BITS (INDEX_BITS),
    .MAX_KICKS  (MAX_KICKS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .cmd     (cmd),
    .sts     (sts),
    .m_tdata (m_tdata)
  );

  `CHT_ASSERT_NEXT(a_one_item, clk, rst, s_tvalid && s_tready, !s_tready, "input taken while busy")
  `CHT_ASSERT_SAME(a_port_excl, clk, rst, cmd.wr_ins || cmd.wr_clear, !cmd.rd_en, "table read and write collide")
  `CHT_ASSERT_SAME(a_res_excl, clk, rst, m_tvalid, !(m_tdata[0] && m_tdata[30]), "found and insert_failed both set")
  `CHT_ASSERT_SAME(a_miss_zero, clk, rst, m_tvalid && !m_tdata[0], m_tdata[16:1] == '0, "payload on a miss")

endmodule

`default_nettype wire
